// File: hdl/ts_continuity_counter_checker_top_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n in scope.
`ifndef TS_CONTINUITY_COUNTER_CHECKER_TOP_MACROS_SVH
`define TS_CONTINUITY_COUNTER_CHECKER_TOP_MACROS_SVH

// Same-cycle implication.
`define TSCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tscc_pkg.sv
`default_nettype none

package tscc_pkg;

	localparam logic [12:0] NULL_PID = 13'h1FFF;
	localparam logic [7:0] DUP_LIMIT = 8'd2;
	localparam logic [7:0] DUP_MAX = 8'd255;
	localparam int QDEPTH = 2;

	// Error kinds reported with each word.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_DUP        = 2'd1;
	localparam logic [1:0] ERR_NO_PAYLOAD = 2'd2;
	localparam logic [1:0] ERR_MISSING    = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GENERATOR_MODE = 2'd0;
	localparam logic [1:0] CFG_FIX_ENABLE     = 2'd1;
	localparam logic [1:0] CFG_REPLICATE_DUPS = 2'd2;

	typedef struct packed {
		logic [12:0] pid;
		logic        pid_enabled;
		logic [3:0]  cc_in;
		logic        payload_present;
		logic        discontinuity_flag;
		logic [31:0] content_digest;
		logic        may_modify;
	} item_t;

	typedef struct packed {
		logic        processed;
		logic [3:0]  cc_out;
		logic        discontinuity_out;
		logic        packet_changed;
		logic [1:0]  error_kind;
		logic [3:0]  missing_count;
		logic [7:0]  duplicate_run;
		logic        all_ok;
		logic [31:0] error_total;
		logic [31:0] fix_total;
	} result_t;

	// Queue entry: the header plus the front's classification.
	typedef struct packed {
		logic  processed;
		item_t item;
	} qent_t;

	typedef struct packed {
		logic generator_mode;
		logic fix_enable;
		logic replicate_duplicates;
	} cfg_t;

	typedef enum logic {
		BK_FETCH,
		BK_EXEC
	} back_state_t;

	function automatic logic [3:0] cc_next(input logic [3:0] cc, input logic payload);
		return payload ? cc + 4'd1 : cc;
	endfunction

endpackage

`default_nettype wire

// File: hdl/tscc_front.sv
`default_nettype none

// Classifies incoming headers and holds them in a two-entry queue.
module tscc_front #(
	parameter int PID_COUNT = 8192
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tscc_pkg::item_t item,
	output logic                full,
	output logic                q_valid,
	output tscc_pkg::qent_t     q_entry,
	input  wire logic           pop
);

	tscc_pkg::qent_t slot_q [tscc_pkg::QDEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            processed;

	// A header is processed only for an enabled, in-range, non-null PID.
	assign processed = (item.pid != tscc_pkg::NULL_PID) && (int'(item.pid) < PID_COUNT)
		&& item.pid_enabled;

	assign full    = (cnt_q == 2'(tscc_pkg::QDEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{processed: processed, item: item};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/tscc_back.sv
`default_nettype none

// Per-PID context memory, continuity check and counter rewrite.
module tscc_back #(
	parameter int PID_COUNT   = 8192,
	parameter int DIGEST_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tscc_pkg::cfg_t  cfg,
	input  wire logic            q_valid,
	input  wire tscc_pkg::qent_t q_entry,
	output logic                 pop,
	output logic                 clearing,
	output logic                 result_valid,
	output tscc_pkg::result_t    result
);

	localparam int AW       = $clog2(PID_COUNT);
	localparam int DW       = (DIGEST_BITS < 32) ? DIGEST_BITS : 32;
	localparam int RW       = DW + 17;
	localparam int DRUN_LO  = DW;
	localparam int LOUT_LO  = DW + 8;
	localparam int LIN_LO   = DW + 12;
	localparam int SEEN_BIT = DW + 16;

	// Row: seen, last received CC, last sent CC, duplicate run, last digest.
	logic [RW-1:0] mem [PID_COUNT];

	tscc_pkg::back_state_t state_q, state_d;
	tscc_pkg::qent_t       ent_s1;
	logic [RW-1:0]         rd_q;
	logic                  clr_active_q;
	logic [AW-1:0]         clr_addr_q;
	logic [31:0]           err_cnt_q;
	logic [31:0]           fix_cnt_q;
	tscc_pkg::result_t     result_q;
	logic                  result_valid_q;

	logic                  exec;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [RW-1:0]         mem_wd;
	logic [RW-1:0]         row_wd;
	tscc_pkg::result_t     res_d;
	logic                  err_inc;
	logic                  fix_inc;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tscc_pkg::BK_FETCH: begin
				if (!clr_active_q && q_valid) begin
					state_d = tscc_pkg::BK_EXEC;
				end
			end
			tscc_pkg::BK_EXEC: begin
				state_d = tscc_pkg::BK_FETCH;
			end
			default: begin
				state_d = tscc_pkg::BK_FETCH;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		pop  = 1'b0;
		exec = 1'b0;
		unique case (state_q)
			tscc_pkg::BK_FETCH: begin
				pop = !clr_active_q && q_valid;
			end
			tscc_pkg::BK_EXEC: begin
				exec = 1'b1;
			end
			default: begin
				pop  = 1'b0;
				exec = 1'b0;
			end
		endcase
	end

	// Continuity check on the fetched context.
	always_comb begin
		tscc_pkg::item_t it;
		logic            seen;
		logic [3:0]      lin;
		logic [3:0]      lout;
		logic [7:0]      drun;
		logic [DW-1:0]   ldig;
		logic [DW-1:0]   dig;
		logic            dup;
		logic [7:0]      dsat;
		logic [7:0]      drun_new;
		logic [3:0]      want;
		logic [3:0]      good_in;
		logic [3:0]      good_out;
		logic [3:0]      cc_o;
		logic            disc_o;
		logic            changed;
		logic [1:0]      kind;
		logic [3:0]      missing;
		logic [7:0]      run;

		it       = ent_s1.item;
		seen     = rd_q[SEEN_BIT];
		lin      = rd_q[LIN_LO +: 4];
		lout     = rd_q[LOUT_LO +: 4];
		drun     = rd_q[DRUN_LO +: 8];
		ldig     = rd_q[DW-1:0];
		dig      = it.content_digest[DW-1:0];
		dup      = seen && !it.discontinuity_flag && (it.cc_in == lin) && (dig == ldig);
		dsat     = (drun != tscc_pkg::DUP_MAX) ? drun + 8'd1 : drun;
		want     = (cfg.replicate_duplicates || !it.payload_present) ? lout
			: tscc_pkg::cc_next(lout, 1'b1);
		good_in  = tscc_pkg::cc_next(lin, it.payload_present);
		good_out = tscc_pkg::cc_next(lout, it.payload_present);
		drun_new = drun;
		cc_o     = it.cc_in;
		disc_o   = it.discontinuity_flag;
		changed  = 1'b0;
		kind     = tscc_pkg::ERR_NONE;
		missing  = 4'd0;
		run      = 8'd0;
		err_inc  = 1'b0;
		fix_inc  = 1'b0;

		if (ent_s1.processed) begin
			if (!seen) begin
				drun_new = 8'd0;
			end else if (cfg.generator_mode) begin
				if (it.may_modify) begin
					disc_o  = 1'b0;
					cc_o    = good_out;
					changed = 1'b1;
					fix_inc = 1'b1;
				end
			end else if (it.discontinuity_flag) begin
				drun_new = 8'd0;
			end else if (dup) begin
				drun_new = dsat;
				if (dsat >= tscc_pkg::DUP_LIMIT) begin
					kind    = tscc_pkg::ERR_DUP;
					run     = (dsat != tscc_pkg::DUP_MAX) ? dsat + 8'd1 : tscc_pkg::DUP_MAX;
					err_inc = 1'b1;
				end
				if (it.may_modify && cfg.fix_enable && (it.cc_in != want)) begin
					cc_o    = want;
					changed = 1'b1;
					fix_inc = 1'b1;
				end
			end else begin
				if (it.cc_in != good_in) begin
					if (!it.payload_present && (it.cc_in == tscc_pkg::cc_next(lin, 1'b1))) begin
						kind = tscc_pkg::ERR_NO_PAYLOAD;
					end else begin
						kind    = tscc_pkg::ERR_MISSING;
						missing = it.cc_in - lin - 4'd1;
					end
					err_inc = 1'b1;
				end
				if (it.may_modify && cfg.fix_enable && (it.cc_in != good_out)) begin
					cc_o    = good_out;
					changed = 1'b1;
					fix_inc = 1'b1;
				end
				drun_new = 8'd0;
			end
		end

		row_wd = {1'b1, it.cc_in, cc_o, drun_new, dig};

		res_d.processed         = ent_s1.processed;
		res_d.cc_out            = cc_o;
		res_d.discontinuity_out = disc_o;
		res_d.packet_changed    = changed;
		res_d.error_kind        = kind;
		res_d.missing_count     = missing;
		res_d.duplicate_run     = run;
		res_d.all_ok            = !(err_inc || changed);
		res_d.error_total       = err_cnt_q + 32'(err_inc);
		res_d.fix_total         = fix_cnt_q + 32'(fix_inc);
	end

	// The clearing pass owns the write port until it has swept every row.
	assign mem_we = clr_active_q || (exec && ent_s1.processed);
	assign mem_wa = clr_active_q ? clr_addr_q : ent_s1.item.pid[AW-1:0];
	assign mem_wd = clr_active_q ? '0 : row_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (pop) begin
			rd_q   <= mem[q_entry.item.pid[AW-1:0]];
			ent_s1 <= q_entry;
		end
		if (exec) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tscc_pkg::BK_FETCH;
			clr_active_q   <= 1'b1;
			clr_addr_q     <= '0;
			err_cnt_q      <= 32'd0;
			fix_cnt_q      <= 32'd0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= exec;
			if (clr_active_q) begin
				if (clr_addr_q == AW'(PID_COUNT - 1)) begin
					clr_active_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + AW'(1);
				end
			end
			if (exec) begin
				err_cnt_q <= res_d.error_total;
				fix_cnt_q <= res_d.fix_total;
			end
		end
	end

	assign clearing     = clr_active_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// File: hdl/ts_continuity_counter_checker_top.sv
// Transport stream continuity counter checker.
// Input channel: one packet header word is taken at a rising edge where start
// is high and busy is low. The header carries PID, filter hit, CC, payload
// and discontinuity flags, a content digest and permission to rewrite.
// Result channel: result_valid is high for exactly one cycle with the result
// word on result; the receiver must take it then, it cannot stall the block.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write registers only while the block is idle.
// When the block is idle an accepted header is queued, fetched with its
// per-PID context row and checked, and its result word is registered as the
// result strobe rises. Headers are processed one at a time: the per-PID
// context memory is read in the fetch state and written back in the execute
// state, and the following header is fetched only after that write-back.
// A two-entry queue lets start be taken while the back end is working; busy
// rises when that queue is full.
// After reset the context memory is swept once to clear every seen bit, one
// row a cycle through all PID_COUNT rows; busy stays high during that sweep.
// Reset also clears the configuration registers and the running error and
// fix totals.
`default_nettype none

module ts_continuity_counter_checker_top #(
	parameter int PID_COUNT   = 8192,
	parameter int DIGEST_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire tscc_pkg::item_t   item,
	output logic                   result_valid,
	output tscc_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic              cfg_data
);

	tscc_pkg::cfg_t  cfg_q;
	tscc_pkg::qent_t q_entry;
	logic            q_full;
	logic            q_valid;
	logic            q_pop;
	logic            clearing;
	logic            push;

	// Configuration writes are never held off.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tscc_pkg::CFG_GENERATOR_MODE: cfg_q.generator_mode       <= cfg_data;
				tscc_pkg::CFG_FIX_ENABLE:     cfg_q.fix_enable           <= cfg_data;
				tscc_pkg::CFG_REPLICATE_DUPS: cfg_q.replicate_duplicates <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Headers wait while the context memory is being cleared or the queue is full.
	assign busy = clearing || q_full;
	assign push = start && !busy;

	tscc_front #(
		.PID_COUNT(PID_COUNT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (q_full),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.pop    (q_pop)
	);

	tscc_back #(
		.PID_COUNT  (PID_COUNT),
		.DIGEST_BITS(DIGEST_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.pop         (q_pop),
		.clearing    (clearing),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

`default_nettype wire

// File: hdl/tscc_checker.sv
`default_nettype none

`include "ts_continuity_counter_checker_top_macros.svh"

// Port-level checks on the result channel.
module tscc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              result_valid,
	input wire tscc_pkg::result_t result
);

	// Each header passes through a fetch state and an execute state in the back end.
	`TSCC_ASSERT_NEXT(a_strobe_spacing, result_valid, !result_valid, "results back to back")

	`TSCC_ASSERT_NOW(a_skip_clean, result_valid && !result.processed, result.all_ok && (result.error_kind == tscc_pkg::ERR_NONE) && !result.packet_changed, "skipped packet reported a change")

	`TSCC_ASSERT_NOW(a_ok_flag, result_valid && (result.packet_changed || (result.error_kind != tscc_pkg::ERR_NONE)), !result.all_ok, "all_ok set with error or change")

	`TSCC_ASSERT_NOW(a_missing_count, result_valid, (result.error_kind == tscc_pkg::ERR_MISSING) == (result.missing_count != 4'd0), "missing count does not match error kind")

endmodule

bind ts_continuity_counter_checker_top tscc_checker u_tscc_checker (.*);

`default_nettype wire
